/* rtl/fedl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the feedback echo delay line.
package fedl_pkg;

  localparam int DATA_W      = 16;  // audio sample width
  localparam int DELAY_W     = 14;  // delay register width
  localparam int GAIN_W      = 16;  // Q1.15 gain width
  localparam int FRAC_BITS   = 15;
  localparam int PROD_W      = DATA_W + GAIN_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0] gain_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DELAY = 2'd0,
    REG_DRY   = 2'd1,
    REG_WET   = 2'd2
  } cfg_reg_t;

  localparam logic [DELAY_W-1:0] RESET_DELAY = 14'd12000;
  localparam gain_t              RESET_DRY   = 16'sh6000;
  localparam gain_t              RESET_WET   = 16'sh2000;

  localparam sample_t SAT_MAX = 16'sh7FFF;
  localparam sample_t SAT_MIN = 16'sh8000;

endpackage

/* rtl/fedl_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (read-first).
module fedl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/fedl_front.sv */
`timescale 1ns / 1ps
// Front end: delay reduction, write pointer, read address and fill check per beat.
module fedl_front #(
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        delay_we,
  input  logic [fedl_pkg::DELAY_W-1:0] delay_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        push_ready,
  output logic                        push,
  output logic [AW-1:0]               rd_addr,
  output logic [AW-1:0]               wr_addr,
  output logic                        written
);

  localparam int DW       = fedl_pkg::DELAY_W;
  localparam int LOG_D    = $clog2(DEPTH);
  localparam int RECIP_SH = DW + LOG_D;
  localparam int RECIP_W  = DW + 2;
  localparam int MUL_W    = DW + RECIP_W;
  // floor(2^RECIP_SH / DEPTH) + 1 gives the exact quotient for any 14-bit delay
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((longint'(1) << RECIP_SH) / longint'(DEPTH) + longint'(1));
  localparam logic [DW-1:0] DEPTH_LO   = DW'(DEPTH);
  localparam logic [DW-1:0] RESET_QUOT = DW'(int'(fedl_pkg::RESET_DELAY) / DEPTH);

  logic [DW-1:0]    dly_r, dly_nxt;
  logic [DW-1:0]    quot_r, quot_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic             pend_r, pend_nxt;
  logic [MUL_W-1:0] recip_prod;
  logic [DW-1:0]    quot_depth;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic             busy;
  logic [AW-1:0]    tap_dist;
  logic [AW:0]      diff;
  logic [AW:0]      diff_wrap;

  // delay mod DEPTH: reciprocal multiply on the write edge, multiply-subtract next cycle
  always_comb begin
    busy       = pend_r;
    recip_prod = MUL_W'(delay_data) * MUL_W'(RECIP);
    // quotient times depth never exceeds the delay, so 14 bits hold it exactly
    quot_depth = quot_r * DEPTH_LO;
    dly_nxt    = dly_r;
    quot_nxt   = quot_r;
    pend_nxt   = 1'b0;
    rem_nxt    = pend_r ? (dly_r - quot_depth) : rem_r;
    if (delay_we) begin
      dly_nxt  = delay_data;
      quot_nxt = DW'(recip_prod >> RECIP_SH);
      pend_nxt = 1'b1;
    end
  end

  always_comb begin
    tap_dist  = AW'(rem_r);
    diff      = {1'b0, wp_r} - {1'b0, tap_dist};
    diff_wrap = diff + (AW+1)'(DEPTH);
    rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
    wr_addr   = wp_r;
    // fill check: slots below wp were written this lap, all once wrapped
    written   = wrapped_r || (rd_addr < wp_r);
    in_tready = !busy && push_ready;
    push      = in_tvalid && in_tready;
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (push) begin
      if (wp_r == AW'(DEPTH - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r     <= fedl_pkg::RESET_DELAY;
      quot_r    <= RESET_QUOT;
      rem_r     <= '0;
      pend_r    <= 1'b1;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      dly_r     <= dly_nxt;
      quot_r    <= quot_nxt;
      rem_r     <= rem_nxt;
      pend_r    <= pend_nxt;
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

endmodule

/* rtl/fedl_queue.sv */
`timescale 1ns / 1ps
// Small register FIFO between front and back ends.
module fedl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r;

  assign push_ready = (count_r != (PW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/fedl_back.sv */
`timescale 1ns / 1ps
// Back end: delay read, forwarding, gain multiply, sum/saturate, write-back, output reg.
module fedl_back #(
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fedl_pkg::gain_t               dry_gain,
  input  fedl_pkg::gain_t               wet_gain,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  fedl_pkg::sample_t             q_x,
  input  logic [AW-1:0]                 q_rd,
  input  logic [AW-1:0]                 q_wp,
  input  logic                          q_written,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fedl_pkg::DATA_W-1:0]   out_tdata
);

  // stage B1: delay read data returns, multiplies
  logic                      b1_v_r;
  fedl_pkg::sample_t         b1_x_r;
  logic [AW-1:0]             b1_rd_r, b1_wp_r;
  logic                      b1_written_r;
  logic                      fwd_hit_r;
  fedl_pkg::sample_t         fwd_data_r;
  // stage P: products, sum and saturate, memory write
  logic                      p_v_r;
  logic [AW-1:0]             p_wp_r;
  logic signed [fedl_pkg::PROD_W-1:0] p_prod_x_r, p_prod_y_r;
  // stage O: output register
  logic                      o_v_r;
  fedl_pkg::sample_t         o_y_r;

  logic [fedl_pkg::DATA_W-1:0] ram_rdata;
  logic                      o_ready, p_ready, p_adv, b1_adv, b1_ready;
  fedl_pkg::sample_t         yd, y_p;
  logic signed [fedl_pkg::PROD_W-1:0] prod_x, prod_y;
  logic signed [fedl_pkg::SUM_W-1:0]  sum_p;
  logic signed [fedl_pkg::SUM_W-fedl_pkg::FRAC_BITS-1:0] shr_p;

  always_comb begin
    o_ready  = !o_v_r || out_tready;
    p_ready  = !p_v_r || o_ready;
    p_adv    = p_v_r && o_ready;
    // an item whose source slot is still in P waits for that write to forward
    b1_adv   = b1_v_r && p_ready && !(p_v_r && (p_wp_r == b1_rd_r));
    b1_ready = !b1_v_r || b1_adv;
    q_pop    = q_valid && b1_ready;
  end

  always_comb begin
    if (!b1_written_r) begin
      yd = '0;
    end else if (fwd_hit_r) begin
      yd = fwd_data_r;
    end else begin
      yd = fedl_pkg::sample_t'(ram_rdata);
    end
    prod_x = b1_x_r * dry_gain;
    prod_y = yd * wet_gain;
  end

  always_comb begin
    sum_p = fedl_pkg::SUM_W'(p_prod_x_r) + fedl_pkg::SUM_W'(p_prod_y_r);
    shr_p = sum_p[fedl_pkg::SUM_W-1:fedl_pkg::FRAC_BITS];  // floor shift
    if (shr_p > (fedl_pkg::SUM_W-fedl_pkg::FRAC_BITS)'(fedl_pkg::SAT_MAX)) begin
      y_p = fedl_pkg::SAT_MAX;
    end else if (shr_p < (fedl_pkg::SUM_W-fedl_pkg::FRAC_BITS)'(fedl_pkg::SAT_MIN)) begin
      y_p = fedl_pkg::SAT_MIN;
    end else begin
      y_p = shr_p[fedl_pkg::DATA_W-1:0];
    end
  end

  fedl_ram #(
    .WIDTH (fedl_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (p_adv),
    .waddr (p_wp_r),
    .wdata (y_p),
    .re    (q_pop),
    .raddr (q_rd),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      p_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        b1_v_r <= 1'b1;
      end else if (b1_adv) begin
        b1_v_r <= 1'b0;
      end
      if (b1_adv) begin
        p_v_r <= 1'b1;
      end else if (p_adv) begin
        p_v_r <= 1'b0;
      end
      if (p_adv) begin
        o_v_r <= 1'b1;
      end else if (out_tready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_x_r       <= q_x;
      b1_rd_r      <= q_rd;
      b1_wp_r      <= q_wp;
      b1_written_r <= q_written;
      // catch a write landing on the same edge as the read
      fwd_hit_r    <= p_adv && (p_wp_r == q_rd);
      fwd_data_r   <= y_p;
    end else if (p_adv && (p_wp_r == b1_rd_r)) begin
      fwd_hit_r  <= 1'b1;
      fwd_data_r <= y_p;
    end
    if (b1_adv) begin
      p_wp_r     <= b1_wp_r;
      p_prod_x_r <= prod_x;
      p_prod_y_r <= prod_y;
    end
    if (p_adv) begin
      o_y_r <= y_p;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_y_r;

endmodule

/* rtl/feedback_echo_delay_line.sv */
`timescale 1ns / 1ps
// Top level of the feedback echo delay line (feedback comb filter).
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata[15:0]  audio_in (s16)
//  out_    | out | out_tvalid / out_tready| out_tdata[15:0] echo_sample (s16)
//  cfg_    | in  | cfg_we (no wait)       | cfg_addr 0 delay, 1 dry, 2 wet gain
//
// One beat per cycle sustained unless output back-pressure, a delay reduction or a
// forwarding wait holds the flow; a beat passes the queue, the delay RAM read, the
// multiply and sum/saturate into the output reg. With an effective delay of one
// sample that rate is not reached: the next beat waits for the previous result's
// write-back to forward into the multiply. After reset and after each delay write,
// in_tready stays low for one cycle while the delay is reduced modulo DELAY_DEPTH
// (reciprocal multiply, then multiply-subtract).
// The delay RAM is not swept at reset: a wrap flag and the write pointer mark unwritten
// slots, which read as zero. Output stalls back up through a 4-deep queue to in_tready.
module feedback_echo_delay_line #(
  parameter int DELAY_DEPTH = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // audio_in [15:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fedl_pkg::DATA_W-1:0]       in_tdata,
  // echo_sample [15:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fedl_pkg::DATA_W-1:0]       out_tdata,
  input  logic                              cfg_we,
  input  logic [fedl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fedl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int QW = fedl_pkg::DATA_W + 2 * AW + 1;

  fedl_pkg::gain_t dry_gain_r, dry_gain_nxt;
  fedl_pkg::gain_t wet_gain_r, wet_gain_nxt;
  logic            delay_we;

  logic            push, push_ready;
  logic [AW-1:0]   f_rd, f_wp;
  logic            f_written;
  logic [QW-1:0]   q_in, q_out;
  logic            q_valid, q_pop;

  // register writes; index 3 is ignored
  always_comb begin
    dry_gain_nxt = dry_gain_r;
    wet_gain_nxt = wet_gain_r;
    delay_we     = 1'b0;
    if (cfg_we) begin
      unique case (fedl_pkg::cfg_reg_t'(cfg_addr))
        fedl_pkg::REG_DELAY: delay_we     = 1'b1;
        fedl_pkg::REG_DRY:   dry_gain_nxt = fedl_pkg::gain_t'(cfg_wdata);
        fedl_pkg::REG_WET:   wet_gain_nxt = fedl_pkg::gain_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_gain_r <= fedl_pkg::RESET_DRY;
      wet_gain_r <= fedl_pkg::RESET_WET;
    end else begin
      dry_gain_r <= dry_gain_nxt;
      wet_gain_r <= wet_gain_nxt;
    end
  end

  fedl_front #(
    .DEPTH (DELAY_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .delay_we   (delay_we),
    .delay_data (cfg_wdata[fedl_pkg::DELAY_W-1:0]),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .push_ready (push_ready),
    .push       (push),
    .rd_addr    (f_rd),
    .wr_addr    (f_wp),
    .written    (f_written)
  );

  assign q_in = {f_written, f_wp, f_rd, in_tdata};

  fedl_queue #(
    .WIDTH (QW),
    .DEPTH (fedl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (q_in),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  fedl_back #(
    .DEPTH (DELAY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dry_gain   (dry_gain_r),
    .wet_gain   (wet_gain_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_x        (fedl_pkg::sample_t'(q_out[fedl_pkg::DATA_W-1:0])),
    .q_rd       (q_out[fedl_pkg::DATA_W +: AW]),
    .q_wp       (q_out[fedl_pkg::DATA_W + AW +: AW]),
    .q_written  (q_out[QW-1]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/fedl_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the feedback echo delay line, with its bind.
module fedl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [fedl_pkg::DATA_W-1:0]     in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fedl_pkg::DATA_W-1:0]     out_tdata,
  input logic                            cfg_we,
  input logic [fedl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [fedl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // delay reduction runs right out of reset
  a_reset_busy: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("input ready during delay reduction after reset");

  // a delay write blocks input while it is reduced
  a_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_addr == fedl_pkg::REG_DELAY) |=> !in_tready)
    else $error("input ready right after delay write");

endmodule

bind feedback_echo_delay_line fedl_checker u_fedl_checker (.*);
